>>> hw/rtl/polynomial_trig_unit_macros.svh
// Assertion macros shared by the polynomial trig unit checkers.
`ifndef POLYNOMIAL_TRIG_UNIT_MACROS_SVH
`define POLYNOMIAL_TRIG_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define PTU_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define PTU_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/ptu_pkg.sv
// Types, constants and arithmetic helpers of the polynomial trig unit.
package ptu_pkg;

	localparam int ANGLE_W = 20;
	localparam int VAL_W   = 22;
	localparam int IFRAC   = 28;
	localparam int DW      = 34;
	localparam int RTW     = 29;
	localparam int VW      = 2 * RTW;
	localparam int RMW     = 32;
	localparam int NSTG    = 17;
	localparam int NCOEF   = 9;

	localparam longint QD          = 64'sd10000000000;
	localparam longint ONE_Q28     = 64'sd1 <<< IFRAC;
	localparam longint HALF_PI_Q28 = 64'sd421657428;

	typedef enum logic [2:0] {
		ACT_SIN  = 3'd0,
		ACT_COS  = 3'd1,
		ACT_TAN  = 3'd2,
		ACT_ASIN = 3'd3,
		ACT_ACOS = 3'd4,
		ACT_ATAN = 3'd5
	} act_t;

	typedef logic signed [DW-1:0] fix_t;

	// One pipeline slot: operands, Horner accumulator and square root state.
	typedef struct packed {
		logic [2:0]     act;
		logic           bad;
		fix_t           x;
		fix_t           t;
		fix_t           p;
		logic [VW-1:0]  v;
		logic [RMW-1:0] rem;
		logic [RTW-1:0] root;
	} stg_t;

	// Decimal coefficient scaled by 1e10, turned into Q.28 rounded to nearest.
	function automatic longint q28(longint n);
		return ((n <<< IFRAC) + QD / 2) / QD;
	endfunction

	// Coefficient rows, constant term first, padded with zeros at the top.
	localparam longint CF [5][NCOEF] = '{
		'{ONE_Q28, -q28(64'sd1666666664), q28(64'sd83333315), -q28(64'sd1984090),
			q28(64'sd27526), -q28(64'sd239), 64'sd0, 64'sd0, 64'sd0},
		'{ONE_Q28, -q28(64'sd4999999963), q28(64'sd416666418), -q28(64'sd13888397),
			q28(64'sd247609), -q28(64'sd2605), 64'sd0, 64'sd0, 64'sd0},
		'{ONE_Q28, q28(64'sd3333314036), q28(64'sd1333923995), q28(64'sd533740603),
			q28(64'sd245650893), q28(64'sd29005250), q28(64'sd95168091),
			64'sd0, 64'sd0},
		'{q28(64'sd15707963050), -q28(64'sd2145988016), q28(64'sd889789874),
			-q28(64'sd501743046), q28(64'sd308918810), -q28(64'sd170881256),
			q28(64'sd66700901), -q28(64'sd12624911), 64'sd0},
		'{ONE_Q28, -q28(64'sd3333314528), q28(64'sd1999355085),
			-q28(64'sd1420889944), q28(64'sd1065626393), -q28(64'sd752896400),
			q28(64'sd429096138), -q28(64'sd161657367), q28(64'sd28662257)}
	};

	// Coefficient lookup; arcsine and arccosine share one row.
	function automatic fix_t coef(logic [2:0] act, int idx);
		int row;
		case (act)
			ACT_SIN:  row = 0;
			ACT_COS:  row = 1;
			ACT_TAN:  row = 2;
			ACT_ASIN: row = 3;
			ACT_ACOS: row = 3;
			ACT_ATAN: row = 4;
			default:  row = 0;
		endcase
		return DW'(CF[row][idx]);
	endfunction

	// Q.28 product of magnitudes, rounded to nearest with ties away from zero.
	function automatic fix_t mulq(fix_t a, fix_t b);
		logic            neg;
		logic [DW-1:0]   ma;
		logic [DW-1:0]   mb;
		logic [2*DW-1:0] prod;
		logic [DW-1:0]   m;
		neg  = a[DW-1] ^ b[DW-1];
		ma   = a[DW-1] ? -a : a;
		mb   = b[DW-1] ? -b : b;
		prod = ma * mb + ((2*DW)'(1) << (IFRAC - 1));
		m    = prod[IFRAC +: DW];
		return neg ? -$signed(m) : $signed(m);
	endfunction

	// One restoring square root step: takes two operand bits, yields one root bit.
	function automatic stg_t sqrt_step(stg_t s);
		stg_t           n;
		logic [RMW-1:0] rsh;
		logic [RMW-1:0] trial;
		n     = s;
		rsh   = {s.rem[RMW-3:0], s.v[VW-1 -: 2]};
		trial = {1'b0, s.root, 2'b01};
		if (rsh >= trial) begin
			n.rem  = rsh - trial;
			n.root = {s.root[RTW-2:0], 1'b1};
		end else begin
			n.rem  = rsh;
			n.root = {s.root[RTW-2:0], 1'b0};
		end
		n.v = {s.v[VW-3:0], 2'b00};
		return n;
	endfunction

endpackage

>>> hw/rtl/ptu_if.sv
// Valid/ready stream interfaces for the argument and result items.
interface ptu_arg_if import ptu_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [2:0]                action;
	logic signed [ANGLE_W-1:0] angle;

	modport source (output valid, output action, output angle, input ready);
	modport sink (input valid, input action, input angle, output ready);
endinterface

interface ptu_res_if import ptu_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic                    out_of_range;

	modport source (output valid, output value, output out_of_range, input ready);
	modport sink (input valid, input value, input out_of_range, output ready);
endinterface

>>> hw/rtl/polynomial_trig_unit.sv
// Pipelined polynomial approximation of sine, cosine, tangent and inverse functions.
// Each stage holds at most one multiplier and two root bits; an output register drives res.
// Throughput: one item per cycle while res.ready does not stall the pipeline.
// A stage moves on whenever the stage after it is empty or moving, so bubbles fill.
// Reset clears every valid bit at once; the data registers are not reset.
module polynomial_trig_unit import ptu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic     clk,
	input logic     arst_n,
	ptu_arg_if.sink   arg,
	ptu_res_if.source res
);

	localparam int SH = IFRAC - FRAC_BITS;
	localparam int XW = ANGLE_W + SH;

	// Work done between stage k-1 and stage k.
	function automatic stg_t advance(stg_t s, int k);
		stg_t n;
		fix_t op;
		fix_t m;
		int   it;
		n = s;
		if (k == 2) begin
			n.t = (s.act == ACT_ASIN || s.act == ACT_ACOS) ? s.x : mulq(s.x, s.x);
			n.p = coef(s.act, NCOEF - 1);
		end
		if (k >= 3 && k <= 10) begin
			n.p = coef(s.act, 10 - k) + mulq(s.t, s.p);
		end
		if (k >= 2 && k <= 16) begin
			for (int j = 0; j < 2; j++) begin
				it = 2 * (k - 2) + j;
				if (it < RTW) begin
					n = sqrt_step(n);
				end
			end
		end
		if (k == NSTG) begin
			op = (s.act == ACT_ASIN || s.act == ACT_ACOS) ? fix_t'(s.root) : s.x;
			m  = mulq(op, s.p);
			if (s.act == ACT_COS) begin
				n.p = s.p;
			end else if (s.act == ACT_ASIN) begin
				n.p = fix_t'(HALF_PI_Q28) - m;
			end else begin
				n.p = m;
			end
		end
		return n;
	endfunction

	stg_t              stg_s [1:NSTG];
	stg_t              nxt   [2:NSTG];
	stg_t              nxt_in;
	logic [NSTG:1]     vld_s;
	logic [NSTG+1:1]   rdy;
	logic signed [XW-1:0] x_wide;
	fix_t              x_in;
	fix_t              d_full;
	logic              bad_in;
	logic                    vld_s18;
	logic signed [VAL_W-1:0] value_s18;
	logic                    oor_s18;

	// Argument scaling to Q.28 and range check on the full-width value.
	assign x_wide = XW'(arg.angle) <<< SH;
	assign x_in   = DW'(x_wide);
	assign d_full = fix_t'(ONE_Q28) - x_in;

	always_comb begin
		case (arg.action)
			ACT_SIN, ACT_COS, ACT_TAN:
				bad_in = (x_wide < 0) || (x_wide > HALF_PI_Q28);
			ACT_ASIN, ACT_ACOS:
				bad_in = (x_wide < 0) || (x_wide > ONE_Q28);
			ACT_ATAN:
				bad_in = (x_wide < -ONE_Q28) || (x_wide > ONE_Q28);
			default:
				bad_in = 1'b1;
		endcase
	end

	always_comb begin
		nxt_in      = '0;
		nxt_in.act  = arg.action;
		nxt_in.bad  = bad_in;
		nxt_in.x    = x_in;
		nxt_in.t    = x_in;
		nxt_in.v    = {1'b0, d_full[RTW-1:0], {IFRAC{1'b0}}};
	end

	for (genvar k = 2; k <= NSTG; k++) begin : g_stage
		assign nxt[k] = advance(stg_s[k-1], k);
	end

	// Stall chain: a stage may load when it is empty or the next one moves.
	assign rdy[NSTG+1] = !vld_s18 || res.ready;
	for (genvar k = 1; k <= NSTG; k++) begin : g_rdy
		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end
	assign arg.ready = rdy[1];

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vld_s18 <= 1'b0;
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= arg.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
			if (rdy[NSTG+1]) begin
				vld_s18 <= vld_s[NSTG];
			end
		end
	end

	// Stage data.
	always_ff @(posedge clk) begin
		if (rdy[1] && arg.valid) begin
			stg_s[1] <= nxt_in;
		end
		for (int k = 2; k <= NSTG; k++) begin
			if (rdy[k] && vld_s[k-1]) begin
				stg_s[k] <= nxt[k];
			end
		end
	end

	// Rounding to the output format, saturation and the out-of-range zero.
	fix_t                    r_fin;
	logic [DW-1:0]           r_mag;
	logic [DW-1:0]           r_rnd;
	logic signed [VAL_W-1:0] value_nxt;

	assign r_fin = stg_s[NSTG].p;
	assign r_mag = r_fin[DW-1] ? -r_fin : r_fin;
	assign r_rnd = (r_mag + (DW'(1) << (SH - 1))) >> SH;

	always_comb begin
		if (stg_s[NSTG].bad) begin
			value_nxt = '0;
		end else if (!r_fin[DW-1]) begin
			value_nxt = (r_rnd > DW'(2**(VAL_W-1) - 1)) ?
				VAL_W'(2**(VAL_W-1) - 1) : r_rnd[VAL_W-1:0];
		end else begin
			value_nxt = (r_rnd > DW'(2**(VAL_W-1))) ?
				{1'b1, {(VAL_W-1){1'b0}}} : -r_rnd[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NSTG+1] && vld_s[NSTG]) begin
			value_s18 <= value_nxt;
			oor_s18   <= stg_s[NSTG].bad;
		end
	end

	assign res.valid        = vld_s18;
	assign res.value        = value_s18;
	assign res.out_of_range = oor_s18;

endmodule

>>> hw/rtl/ptu_checker.sv
// Port-level checker of the polynomial trig unit and its bind statement.
`include "polynomial_trig_unit_macros.svh"

module ptu_checker import ptu_pkg::*; #(
	parameter int DEPTH = 18
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    arg_valid,
	input logic                    arg_ready,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic signed [VAL_W-1:0] value,
	input logic                    out_of_range
);

	localparam int CW = $clog2(DEPTH + 2);

	logic [CW-1:0] inflight_q;

	// Items taken in and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CW'(arg_valid && arg_ready)
				- CW'(res_valid && res_ready);
		end
	end

	`PTU_ASSERT_NXT(res_hold, res_valid && !res_ready,
		res_valid && $stable(value) && $stable(out_of_range), "stalled result changed")
	`PTU_ASSERT_IMP(flag_zero, res_valid && out_of_range, value == '0,
		"out-of-range item with nonzero value")
	`PTU_ASSERT_IMP(no_phantom, res_valid, inflight_q != '0,
		"result shown with no item in flight")
	`PTU_ASSERT_IMP(depth_bound, 1'b1, inflight_q <= CW'(DEPTH),
		"more items in flight than pipeline stages")

endmodule

bind polynomial_trig_unit ptu_checker #(.DEPTH(ptu_pkg::NSTG + 1)) u_ptu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.arg_valid    (arg.valid),
	.arg_ready    (arg.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.value        (res.value),
	.out_of_range (res.out_of_range)
);
